FILE: hdl/rcfd_pkg.sv
package rcfd_pkg;

    // Window and frame layout
    localparam int WIN_DEPTH     = 14;
    localparam int HDR_BYTES     = 3;
    localparam int NUM_CH        = 8;
    localparam int CH_BITS       = 11;
    localparam int PAYLOAD_BITS  = (WIN_DEPTH - HDR_BYTES) * 8;
    localparam int PULSE_W       = 12;

    // (5*v + 7040) >> 3 == floor((v - 992) * 5/8 + 1500)
    localparam int SUM_W         = 15;
    localparam logic [SUM_W-1:0] PULSE_OFFSET = SUM_W'(7040);

    // Register reset values
    localparam logic [7:0] SYNC_RESET   = 8'hC8;
    localparam logic [7:0] LENGTH_RESET = 8'h18;
    localparam logic [7:0] TYPE_RESET   = 8'h16;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC   = 2'd0,
        CFG_LENGTH = 2'd1,
        CFG_TYPE   = 2'd2
    } cfg_idx_t;

    typedef logic [7:0]         byte_t;
    typedef logic [CH_BITS-1:0] chan_t;
    typedef logic [PULSE_W-1:0] pulse_t;

endpackage

FILE: hdl/rcfd_cell.sv
module rcfd_cell
    import rcfd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  byte_t d,
    output byte_t q
);

    byte_t q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

FILE: hdl/rcfd_chan_map.sv
module rcfd_chan_map
    import rcfd_pkg::*;
(
    input  chan_t  value,
    output pulse_t pulse
);

    logic [SUM_W-1:0] sum;

    // 5*v by shift-add, then the fixed offset
    assign sum   = {2'b00, value, 2'b00} + {4'b0000, value} + PULSE_OFFSET;
    assign pulse = sum[SUM_W-1:3];

endmodule

FILE: hdl/rc_channel_frame_decoder_top.sv
// Packed RC channel frame decoder. Received bytes enter one per request on the
// input channel and shift through a row of 14 byte cells; the oldest cell is
// dropped on every accepted byte. The cycle after each accepted byte, the three
// oldest cells are compared with the sync, length and type registers; on a
// match the remaining 11 bytes are read as a little-endian bit stream of eight
// 11-bit channels, each mapped to a pulse width (5*v + 7040) >> 3 microseconds,
// and one output request carries all eight widths. No frame lock is kept, so
// any header-like byte pattern inside a frame also matches, and after reset the
// zero-filled cells take part in the compare. A byte is accepted every cycle
// unless held off, and passes the byte cells, then the output register or skid.
// The only hold-off comes from the two-entry output buffer (output register
// plus skid) when the downstream side stalls. Configuration writes are always
// ready and are meant to happen only while the decoder is idle.
module rc_channel_frame_decoder_top
    import rcfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [11:0]          rotate_us,
    output logic [11:0]          throttle_us,
    output logic [11:0]          lift_throttle_us,
    output logic [11:0]          strafe_us,
    output logic [11:0]          safety_switch_us,
    output logic [11:0]          aux_six_us,
    output logic [11:0]          aux_seven_us,
    output logic [11:0]          aux_eight_us
);

    // ---------------- configuration registers ----------------
    byte_t sync_reg;
    byte_t length_reg;
    byte_t type_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg   <= SYNC_RESET;
            length_reg <= LENGTH_RESET;
            type_reg   <= TYPE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // out-of-range index is dropped
            case (cfg_index)
                CFG_SYNC:   sync_reg   <= cfg_data;
                CFG_LENGTH: length_reg <= cfg_data;
                CFG_TYPE:   type_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ---------------- byte window: row of shift cells ----------------
    logic  in_accept;
    byte_t win_q [WIN_DEPTH];

    assign in_accept = in_valid && !in_stall;

    genvar gi;
    generate
        for (gi = 0; gi < WIN_DEPTH; gi++)
        begin : g_cell
            byte_t cell_d;
            if (gi == WIN_DEPTH - 1)
            begin : g_newest
                assign cell_d = data_byte;
            end
            else
            begin : g_inner
                assign cell_d = win_q[gi+1];
            end

            rcfd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (in_accept),
                .d        (cell_d),
                .q        (win_q[gi])
            );
        end
    endgenerate

    // Window changed last cycle, so it has to be evaluated now.
    logic fresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b0;
        end
        else
        begin
            fresh_reg <= in_accept;
        end
    end

    // ---------------- header compare and channel unpack ----------------
    logic                    hdr_match;
    logic                    new_res;
    logic [PAYLOAD_BITS-1:0] payload;
    pulse_t                  pulse [NUM_CH];

    assign hdr_match = (win_q[0] == sync_reg) && (win_q[1] == length_reg) &&
                       (win_q[2] == type_reg);
    assign new_res   = fresh_reg && hdr_match;

    generate
        for (gi = HDR_BYTES; gi < WIN_DEPTH; gi++)
        begin : g_payload
            assign payload[(gi-HDR_BYTES)*8 +: 8] = win_q[gi];
        end

        for (gi = 0; gi < NUM_CH; gi++)
        begin : g_chan
            rcfd_chan_map u_map (
                .value (payload[gi*CH_BITS +: CH_BITS]),
                .pulse (pulse[gi])
            );
        end
    endgenerate

    // ---------------- output register plus skid ----------------
    logic   out_valid_reg;
    logic   skid_valid_reg;
    pulse_t out_reg  [NUM_CH];
    pulse_t skid_reg [NUM_CH];
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // A pending evaluation always finds a free slot: hold off a new byte while
    // the skid is full, or while a pending result could only land in the skid
    // and the byte behind it would then have nowhere to go.
    assign in_stall = skid_valid_reg || (fresh_reg && out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= new_res;
            end
        end
        else if (new_res)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (new_res)
            begin
                out_reg <= pulse;
            end
        end
        else if (new_res)
        begin
            skid_reg <= pulse;
        end
    end

    assign out_valid        = out_valid_reg;
    assign rotate_us        = out_reg[0];
    assign throttle_us      = out_reg[1];
    assign lift_throttle_us = out_reg[2];
    assign strafe_us        = out_reg[3];
    assign safety_switch_us = out_reg[4];
    assign aux_six_us       = out_reg[5];
    assign aux_seven_us     = out_reg[6];
    assign aux_eight_us     = out_reg[7];

endmodule
